>>> rtl/core/stip_pkg.sv
// Shared types and constants for the sorted table insert-position block.
package stip_pkg;

  // Width of one table entry and of a search target.
  localparam int unsigned ValW = 32;

  // Width of the position field of a result word.
  localparam int unsigned PosW = 11;

  // Command codes carried by an input word.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  // Status codes carried by a result word.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Search sequencer states.
  typedef enum logic [2:0] {
    SRCH_IDLE  = 3'b001,
    SRCH_PROBE = 3'b010,
    SRCH_CMP   = 3'b100
  } srch_state_e;

  // Request from the command front end to the search sequencer.
  typedef struct packed {
    logic                   start;
    logic signed [ValW-1:0] target;
  } srch_req_t;

  // Status from the search sequencer back to the front end.
  typedef struct packed {
    logic busy;
    logic done;
  } srch_rsp_t;

endpackage

>>> rtl/core/stip_if.sv
// Valid/ready channel interfaces for command words and result words.
interface stip_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic signed [stip_pkg::ValW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface stip_res_if;
  logic                      valid;
  logic                      ready;
  logic [stip_pkg::PosW-1:0] position;
  logic                      status;

  modport source (output valid, output position, output status, input ready);
  modport sink (input valid, input position, input status, output ready);
endinterface

>>> rtl/core/stip_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
module stip_ram #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic signed [stip_pkg::ValW-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic signed [stip_pkg::ValW-1:0] rdata_o
);

  logic signed [stip_pkg::ValW-1:0] mem_q [DEPTH];
  logic signed [stip_pkg::ValW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/stip_bsearch.sv
// Lower-bound search sequencer sharing one signed comparator over all probes.
module stip_bsearch #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  stip_pkg::srch_req_t               req_i,
  input  logic [$clog2(DEPTH+1)-1:0]        count_i,
  output stip_pkg::srch_rsp_t               rsp_o,
  output logic [$clog2(DEPTH+1)-1:0]        pos_o,
  output logic                              rd_en_o,
  output logic [$clog2(DEPTH)-1:0]          rd_addr_o,
  input  logic signed [stip_pkg::ValW-1:0]  rd_data_i
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);

  stip_pkg::srch_state_e state_q, state_d;
  logic [CntW-1:0] first_q, first_d;
  logic [CntW-1:0] last_q, last_d;
  logic [CntW-1:0] mid_q, mid_d;
  logic signed [stip_pkg::ValW-1:0] target_q, target_d;
  logic [CntW-1:0] mid;
  logic done;

  // Midpoint of the half-open window; never reaches the count, so it fits an address.
  assign mid = first_q + ((last_q - first_q) >> 1);

  // Sequencer: a probe issues the read, the next cycle compares and narrows.
  always_comb begin
    state_d  = state_q;
    first_d  = first_q;
    last_d   = last_q;
    mid_d    = mid_q;
    target_d = target_q;
    rd_en_o  = 1'b0;
    done     = 1'b0;
    unique case (state_q)
      stip_pkg::SRCH_IDLE: begin
        if (req_i.start) begin
          first_d  = '0;
          last_d   = count_i;
          target_d = req_i.target;
          state_d  = stip_pkg::SRCH_PROBE;
        end
      end
      stip_pkg::SRCH_PROBE: begin
        if (first_q == last_q) begin
          done    = 1'b1;
          state_d = stip_pkg::SRCH_IDLE;
        end else begin
          rd_en_o = 1'b1;
          mid_d   = mid;
          state_d = stip_pkg::SRCH_CMP;
        end
      end
      stip_pkg::SRCH_CMP: begin
        if (target_q > rd_data_i) begin
          first_d = mid_q + CntW'(1);
        end else begin
          last_d = mid_q;
        end
        state_d = stip_pkg::SRCH_PROBE;
      end
      default: begin
        state_d = stip_pkg::SRCH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stip_pkg::SRCH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    last_q   <= last_d;
    mid_q    <= mid_d;
    target_q <= target_d;
  end

  assign rd_addr_o  = mid[AddrW-1:0];
  assign pos_o      = first_q;
  assign rsp_o.busy = (state_q != stip_pkg::SRCH_IDLE);
  assign rsp_o.done = done;

endmodule

>>> rtl/core/sorted_table_insert_position.sv
// Top level of the sorted table with lower-bound search.
// For clear, append and the unused command code, the word is accepted and its result word
// is in the output register on the next cycle. A search alternates a probe state, which
// issues the table read, and a compare state, which narrows the window; it needs at most
// floor(log2(count))+1 probes, and a final probe state that finds the window empty loads
// the result. The split comes from the table memory's registered read port: each probe does
// the read and then the compare that picks the next midpoint. The block accepts no new word
// while a search runs. A new word is taken while a result waits only if that result leaves
// in the same cycle. The table needs no clearing pass: only entries below the count are read.
module sorted_table_insert_position #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  stip_cmd_if.sink        cmd_i,
  stip_res_if.source      res_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic [stip_pkg::PosW-1:0] out_pos_q, out_pos_d;
  logic out_status_q, out_status_d;
  logic accept;
  logic wr_en;
  logic rd_en;
  logic [AddrW-1:0] rd_addr;
  logic signed [stip_pkg::ValW-1:0] rd_data;
  logic [CntW-1:0] srch_pos;
  stip_pkg::srch_req_t srch_req;
  stip_pkg::srch_rsp_t srch_rsp;

  // Take a word when no search runs and the result register is free or draining.
  assign cmd_i.ready = !srch_rsp.busy && (!out_valid_q || res_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Command decode, count update and result register load.
  always_comb begin
    cnt_d          = cnt_q;
    out_valid_d    = out_valid_q && !res_o.ready;
    out_pos_d      = out_pos_q;
    out_status_d   = out_status_q;
    wr_en          = 1'b0;
    srch_req.start = 1'b0;
    srch_req.target = cmd_i.value;
    if (accept) begin
      unique case (cmd_i.command)
        stip_pkg::CMD_CLEAR: begin
          cnt_d        = '0;
          out_valid_d  = 1'b1;
          out_pos_d    = '0;
          out_status_d = stip_pkg::STATUS_OK;
        end
        stip_pkg::CMD_APPEND: begin
          out_valid_d = 1'b1;
          if (cnt_q == DepthC) begin
            out_pos_d    = stip_pkg::PosW'(cnt_q);
            out_status_d = stip_pkg::STATUS_FULL;
          end else begin
            wr_en        = 1'b1;
            cnt_d        = cnt_q + CntW'(1);
            out_pos_d    = stip_pkg::PosW'(cnt_q + CntW'(1));
            out_status_d = stip_pkg::STATUS_OK;
          end
        end
        stip_pkg::CMD_SEARCH: begin
          srch_req.start = 1'b1;
        end
        default: begin
          out_valid_d  = 1'b1;
          out_pos_d    = stip_pkg::PosW'(cnt_q);
          out_status_d = stip_pkg::STATUS_OK;
        end
      endcase
    end
    if (srch_rsp.done) begin
      out_valid_d  = 1'b1;
      out_pos_d    = stip_pkg::PosW'(srch_pos);
      out_status_d = stip_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pos_q    <= out_pos_d;
    out_status_q <= out_status_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.position = out_pos_q;
  assign res_o.status   = out_status_q;

  // Table storage.
  stip_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (cmd_i.value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Search sequencer.
  stip_bsearch #(
    .DEPTH (DEPTH)
  ) u_bsearch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (srch_req),
    .count_i   (cnt_q),
    .rsp_o     (srch_rsp),
    .pos_o     (srch_pos),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

endmodule

>>> rtl/core/stip_chk.sv
// Port-level checker for the sorted table block, bound to the top level.
module stip_chk #(
  parameter int unsigned DEPTH = 1024
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cmd_valid_i,
  input logic                      cmd_ready_i,
  input logic [1:0]                cmd_command_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [stip_pkg::PosW-1:0] res_position_i,
  input logic                      res_status_i
);

  logic cmd_acc;

  assign cmd_acc = cmd_valid_i && cmd_ready_i;

  // A waiting result word is not dropped.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  // A word is taken only when the result register can accept its result.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |-> !res_valid_i || res_ready_i)
    else $error("command word accepted over a waiting result");

  // Everything but a search answers on the next cycle.
  a_fast_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_command_i != stip_pkg::CMD_SEARCH) |=> res_valid_i)
    else $error("clear or append result late");

  // A clear reports an empty table.
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_command_i == stip_pkg::CMD_CLEAR)
      |=> (res_position_i == '0) && (res_status_i == stip_pkg::STATUS_OK))
    else $error("clear result not zero");

  // A dropped append only happens at a full table.
  a_full_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == stip_pkg::STATUS_FULL)
      |-> res_position_i == stip_pkg::PosW'(DEPTH))
    else $error("full status with count below depth");

endmodule

bind sorted_table_insert_position stip_chk #(
  .DEPTH (DEPTH)
) u_stip_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .cmd_command_i  (cmd_i.command),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_position_i (res_o.position),
  .res_status_i   (res_o.status)
);
